[rtl/dlsp_pkg.sv]
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared types and constants of the dual linked stack pool.
// ----------------------------------------------------------------------------
package dlsp_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  localparam int DATA_W         = 32;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_MOVE    = 2'd2,
    REQ_RESTORE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MAIN_EMPTY = 2'd1,
    ST_AUX_EMPTY  = 2'd2,
    ST_POOL_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

[rtl/dlsp_controller.sv]
// ----------------------------------------------------------------------------
// dlsp_controller
// Request sequencer: accepts one beat, runs the update step, holds the result.
// ----------------------------------------------------------------------------
module dlsp_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dlsp_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = req_valid && !req_stall;
  assign cmd.load  = accept;
  assign cmd.exec  = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/dlsp_datapath.sv]
// ----------------------------------------------------------------------------
// dlsp_datapath
// Node pool memories, stack and free list pointers, result register.
// ----------------------------------------------------------------------------
module dlsp_datapath #(
  parameter int POOL_DEPTH = dlsp_pkg::POOL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dlsp_pkg::cmd_t                     cmd,
  input  logic [1:0]                         req_type,
  input  logic signed [dlsp_pkg::DATA_W-1:0] push_value,
  output logic signed [dlsp_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                         status,
  output logic                               main_is_empty,
  output logic                               aux_is_empty
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] PTR_NULL = PW'(POOL_DEPTH);

  logic [dlsp_pkg::DATA_W-1:0] node_values [POOL_DEPTH];
  logic [PW-1:0]               node_links  [POOL_DEPTH];

  dlsp_pkg::req_t              req_q;
  logic [dlsp_pkg::DATA_W-1:0] value_q;
  logic [PW-1:0]               main_top;
  logic [PW-1:0]               aux_top;
  logic [PW-1:0]               free_head;
  logic [PW-1:0]               fresh_count;
  logic [dlsp_pkg::DATA_W-1:0] rd_value;
  logic [PW-1:0]               rd_link;

  logic [PW-1:0]               rd_ptr;
  logic [AW-1:0]               rd_addr;

  logic [PW-1:0]               main_top_next;
  logic [PW-1:0]               aux_top_next;
  logic [PW-1:0]               free_head_next;
  logic [PW-1:0]               fresh_count_next;
  logic [PW-1:0]               node;
  logic                        wr_en;
  logic                        wr_val_en;
  logic [PW-1:0]               wr_link;
  logic [dlsp_pkg::DATA_W-1:0] popped;
  dlsp_pkg::status_t           st;

  always_comb begin
    unique case (dlsp_pkg::req_t'(req_type))
      dlsp_pkg::REQ_PUSH:    rd_ptr = free_head;
      dlsp_pkg::REQ_POP:     rd_ptr = main_top;
      dlsp_pkg::REQ_MOVE:    rd_ptr = main_top;
      dlsp_pkg::REQ_RESTORE: rd_ptr = aux_top;
      default:               rd_ptr = PTR_NULL;
    endcase
    rd_addr = (rd_ptr < PTR_NULL) ? rd_ptr[AW-1:0] : '0;
  end

  always_comb begin
    main_top_next    = main_top;
    aux_top_next     = aux_top;
    free_head_next   = free_head;
    fresh_count_next = fresh_count;
    node             = PTR_NULL;
    wr_en            = 1'b0;
    wr_val_en        = 1'b0;
    wr_link          = main_top;
    popped           = '0;
    st               = dlsp_pkg::ST_OK;
    unique case (req_q)
      dlsp_pkg::REQ_PUSH: begin
        priority if (free_head < PTR_NULL) begin
          node           = free_head;
          free_head_next = rd_link;
        end else if (fresh_count < PTR_NULL) begin
          node             = fresh_count;
          fresh_count_next = fresh_count + PW'(1);
        end else begin
          st = dlsp_pkg::ST_POOL_FULL;
        end
        if (node < PTR_NULL) begin
          wr_en         = 1'b1;
          wr_val_en     = 1'b1;
          wr_link       = main_top;
          main_top_next = node;
        end
      end
      dlsp_pkg::REQ_POP: begin
        node = main_top;
        if (node < PTR_NULL) begin
          popped         = rd_value;
          main_top_next  = rd_link;
          wr_en          = 1'b1;
          wr_link        = free_head;
          free_head_next = node;
        end else begin
          popped = '1;
          st     = dlsp_pkg::ST_MAIN_EMPTY;
        end
      end
      dlsp_pkg::REQ_MOVE: begin
        node = main_top;
        if (node < PTR_NULL) begin
          main_top_next = rd_link;
          wr_en         = 1'b1;
          wr_link       = aux_top;
          aux_top_next  = node;
        end else begin
          st = dlsp_pkg::ST_MAIN_EMPTY;
        end
      end
      dlsp_pkg::REQ_RESTORE: begin
        node = aux_top;
        if (node < PTR_NULL) begin
          aux_top_next  = rd_link;
          wr_en         = 1'b1;
          wr_link       = main_top;
          main_top_next = node;
        end else begin
          st = dlsp_pkg::ST_AUX_EMPTY;
        end
      end
      default: st = dlsp_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= dlsp_pkg::req_t'(req_type);
      value_q  <= push_value;
      rd_value <= node_values[rd_addr];
      rd_link  <= node_links[rd_addr];
    end
    if (cmd.exec && wr_en) begin
      node_links[node[AW-1:0]] <= wr_link;
      if (wr_val_en) begin
        node_values[node[AW-1:0]] <= value_q;
      end
    end
    if (cmd.exec) begin
      pop_value     <= popped;
      status        <= st;
      main_is_empty <= !(main_top_next < PTR_NULL);
      aux_is_empty  <= !(aux_top_next < PTR_NULL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_top    <= PTR_NULL;
      aux_top     <= PTR_NULL;
      free_head   <= PTR_NULL;
      fresh_count <= '0;
    end else if (cmd.exec) begin
      main_top    <= main_top_next;
      aux_top     <= aux_top_next;
      free_head   <= free_head_next;
      fresh_count <= fresh_count_next;
    end
  end

endmodule

[rtl/dual_linked_stack_pool_top.sv]
// ----------------------------------------------------------------------------
// dual_linked_stack_pool_top
// Result: a taken request beat loads the registered pool read; the pointer update and
// write-back step then registers the result beat. One request is in work at a time:
// requests are stalled during that step and while a result beat is stalled.
// Reset: both stacks and the free list empty, all nodes fresh; no sweep.
// ----------------------------------------------------------------------------
module dual_linked_stack_pool_top #(
  parameter int POOL_DEPTH = dlsp_pkg::POOL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [dlsp_pkg::DATA_W-1:0] push_value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [dlsp_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                         status,
  output logic                               main_is_empty,
  output logic                               aux_is_empty
);

  dlsp_pkg::cmd_t cmd;

  dlsp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  dlsp_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .push_value    (push_value),
    .pop_value     (pop_value),
    .status        (status),
    .main_is_empty (main_is_empty),
    .aux_is_empty  (aux_is_empty)
  );

endmodule

[rtl/dlsp_checker.sv]
// ----------------------------------------------------------------------------
// dlsp_checker
// Port-level checks of the dual linked stack pool, bound to the top level.
// ----------------------------------------------------------------------------
module dlsp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_stall,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic signed [dlsp_pkg::DATA_W-1:0] pop_value,
  input logic [1:0]                         status,
  input logic                               aux_is_empty
);

  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> ##1 rsp_valid)
    else $error("result beat missing two cycles after request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous still in work");

  a_aux_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == dlsp_pkg::ST_AUX_EMPTY) |-> (aux_is_empty && pop_value == 0))
    else $error("aux empty status inconsistent with flags");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pop_value) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind dual_linked_stack_pool_top dlsp_checker u_dlsp_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .pop_value    (pop_value),
  .status       (status),
  .aux_is_empty (aux_is_empty)
);
